// ----- design/mbrpt_pkg.sv -----
// mbrpt_pkg: shared types, constants and the type-byte classifier for the
// MBR partition table parser. No dependencies.

package mbrpt_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_ENTRY   = 2'd0;
    localparam t_status ST_BAD_SIG = 2'd1;
    localparam t_status ST_GPT     = 2'd2;
    localparam t_status ST_EMPTY   = 2'd3;

    typedef logic [3:0] t_fs_class;

    localparam t_fs_class FS_UNKNOWN = 4'd0;
    localparam t_fs_class FS_FAT12   = 4'd1;
    localparam t_fs_class FS_FAT16   = 4'd2;
    localparam t_fs_class FS_FAT32   = 4'd3;
    localparam t_fs_class FS_NTFS    = 4'd4;
    localparam t_fs_class FS_EXT     = 4'd5;
    localparam t_fs_class FS_SWAP    = 4'd6;
    localparam t_fs_class FS_EFI     = 4'd7;
    localparam t_fs_class FS_GPT     = 4'd8;

    localparam logic [8:0] TABLE_BASE = 9'd446;
    localparam logic [8:0] TABLE_END  = 9'd510;  // first byte past the table
    localparam logic [8:0] SIG_LO_POS = 9'd510;
    localparam logic [8:0] SIG_HI_POS = 9'd511;

    localparam logic [7:0] SIG_LO     = 8'h55;
    localparam logic [7:0] SIG_HI     = 8'hAA;
    localparam logic [7:0] BOOT_FLAG  = 8'h80;
    localparam logic [7:0] TYPE_GPT   = 8'hEE;

    localparam logic [16:0] BLOCK_RESET = 17'd512;

    function automatic t_fs_class classify(input logic [7:0] t);
        t_fs_class c;
        unique case (t) inside
            8'h01:               c = FS_FAT12;
            8'h04, 8'h06, 8'h0E: c = FS_FAT16;
            8'h0B, 8'h0C:        c = FS_FAT32;
            8'h07:               c = FS_NTFS;
            8'h83:               c = FS_EXT;
            8'h82:               c = FS_SWAP;
            8'hEF:               c = FS_EFI;
            8'hEE:               c = FS_GPT;
            default:             c = FS_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

// ----- design/mbr_partition_table_parser.sv -----
// mbr_partition_table_parser: captures the four primary MBR entries from a
// byte stream and emits one record per live entry, or one status record.
// Depends on mbrpt_pkg.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------
//  input    | in        | i_valid / o_stall       | i_data_byte
//  result   | out       | o_valid / i_stall       | o_status .. o_last_of_run
//  config   | in        | i_cfg_valid/o_cfg_ready | i_cfg_data (block_bytes)
//
// One byte is taken per cycle while o_stall is low. Byte 511 of a sector queues
// up to four records, which leave through the output register one per cycle
// while i_stall is low; each record's byte products come from a 32x17 multiplier
// ahead of that register. While records are still queued, bytes 446..511 of the
// next sector are stalled so the captured entries hold until the queue drains.
// Reset (synchronous, active low) clears position, entries, queue and sets
// block_bytes to 512.

module mbr_partition_table_parser
    import mbrpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [2:0]  o_entry_index,
    output logic        o_bootable,
    output logic [7:0]  o_type_code,
    output logic [3:0]  o_fs_class,
    output logic [31:0] o_first_sector,
    output logic [31:0] o_length_sectors,
    output logic [47:0] o_offset_bytes,
    output logic [47:0] o_length_bytes,
    output logic        o_last_of_run
);

    logic [16:0]           r_block;
    logic [8:0]            r_pos;
    logic [3:0]            r_boot,  n_boot;
    logic [3:0][7:0]       r_type,  n_type;
    logic [3:0][3:0][7:0]  r_start, n_start;
    logic [3:0][3:0][7:0]  r_count, n_count;
    logic [7:0]            r_sig,   n_sig;

    // record queue
    logic                  r_pend_valid, n_pend_valid;
    t_status               r_pend_code,  n_pend_code;
    logic [3:0]            r_mask,       n_mask;

    // output register
    logic                  r_out_valid, n_out_valid;
    t_status               r_status,    n_status;
    logic [2:0]            r_index,     n_index;
    logic                  r_bootable,  n_bootable;
    logic [7:0]            r_type_code, n_type_code;
    t_fs_class             r_fs_class,  n_fs_class;
    logic [31:0]           r_first,     n_first;
    logic [31:0]           r_length,    n_length;
    logic [47:0]           r_off_b,     n_off_b;
    logic [47:0]           r_len_b,     n_len_b;
    logic                  r_last,      n_last;

    logic       busy;
    logic       in_acc;
    logic       in_table;
    logic [8:0] rel_full;
    logic [5:0] rel;
    logic [1:0] ent;
    logic [3:0] off;
    logic [3:0] live;
    logic       sig_ok;
    logic       gpt;
    logic       take;
    logic [1:0] sel;
    logic [3:0] rem_mask;
    logic [31:0] sel_start;
    logic [31:0] sel_count;

    assign busy        = r_pend_valid || (r_mask != 4'd0);
    assign o_stall     = busy && (r_pos >= TABLE_BASE);
    assign in_acc      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign in_table = (r_pos >= TABLE_BASE) && (r_pos < TABLE_END);
    assign rel_full = r_pos - TABLE_BASE;
    assign rel      = rel_full[5:0];
    assign ent      = rel[5:4];
    assign off      = rel[3:0];

    // entry capture
    always_comb begin
        n_boot  = r_boot;
        n_type  = r_type;
        n_start = r_start;
        n_count = r_count;
        n_sig   = r_sig;
        if (in_acc && in_table) begin
            if (off == 4'd0) begin
                n_boot[ent] = (i_data_byte == BOOT_FLAG);
            end else if (off == 4'd4) begin
                n_type[ent] = i_data_byte;
            end else if (off[3:2] == 2'b10) begin
                n_start[ent][off[1:0]] = i_data_byte;
            end else if (off[3:2] == 2'b11) begin
                n_count[ent][off[1:0]] = i_data_byte;
            end
        end
        if (in_acc && (r_pos == SIG_LO_POS)) begin
            n_sig = i_data_byte;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            live[i] = (r_type[i] != 8'd0) && (r_count[i] != 32'd0);
        end
    end

    assign sig_ok = (r_sig == SIG_LO) && (i_data_byte == SIG_HI);
    assign gpt    = (r_type[0] == TYPE_GPT) && (r_count[0] != 32'd0);

    // lowest pending entry
    always_comb begin
        sel = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel = 2'(i);
            end
        end
    end

    assign rem_mask  = r_mask & ~(4'd1 << sel);
    assign sel_start = r_start[sel];
    assign sel_count = r_count[sel];
    assign take      = !r_out_valid || !i_stall;

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_code  = r_pend_code;
        n_mask       = r_mask;
        n_out_valid  = r_out_valid;
        n_status     = r_status;
        n_index      = r_index;
        n_bootable   = r_bootable;
        n_type_code  = r_type_code;
        n_fs_class   = r_fs_class;
        n_first      = r_first;
        n_length     = r_length;
        n_off_b      = r_off_b;
        n_len_b      = r_len_b;
        n_last       = r_last;

        if (take) begin
            if (r_pend_valid) begin
                n_pend_valid = 1'b0;
                n_out_valid  = 1'b1;
                n_status     = r_pend_code;
                n_index      = 3'd0;
                n_bootable   = 1'b0;
                n_type_code  = 8'd0;
                n_fs_class   = FS_UNKNOWN;
                n_first      = 32'd0;
                n_length     = 32'd0;
                n_off_b      = 48'd0;
                n_len_b      = 48'd0;
                n_last       = 1'b1;
            end else if (r_mask != 4'd0) begin
                n_mask      = rem_mask;
                n_out_valid = 1'b1;
                n_status    = ST_ENTRY;
                n_index     = {1'b0, sel} + 3'd1;
                n_bootable  = r_boot[sel];
                n_type_code = r_type[sel];
                n_fs_class  = classify(r_type[sel]);
                n_first     = sel_start;
                n_length    = sel_count;
                n_off_b     = 48'(sel_start) * 48'(r_block);
                n_len_b     = 48'(sel_count) * 48'(r_block);
                n_last      = (rem_mask == 4'd0);
            end else begin
                n_out_valid = 1'b0;
            end
        end

        // last byte of the sector: queue is empty here, stall guarantees it
        if (in_acc && (r_pos == SIG_HI_POS)) begin
            if (!sig_ok) begin
                n_pend_valid = 1'b1;
                n_pend_code  = ST_BAD_SIG;
            end else if (gpt) begin
                n_pend_valid = 1'b1;
                n_pend_code  = ST_GPT;
            end else if (live == 4'd0) begin
                n_pend_valid = 1'b1;
                n_pend_code  = ST_EMPTY;
            end else begin
                n_mask = live;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block      <= BLOCK_RESET;
            r_pos        <= 9'd0;
            r_boot       <= '0;
            r_type       <= '0;
            r_start      <= '0;
            r_count      <= '0;
            r_sig        <= 8'd0;
            r_pend_valid <= 1'b0;
            r_pend_code  <= ST_ENTRY;
            r_mask       <= 4'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_block <= i_cfg_data;
            end
            if (in_acc) begin
                r_pos <= r_pos + 9'd1;
            end
            r_boot       <= n_boot;
            r_type       <= n_type;
            r_start      <= n_start;
            r_count      <= n_count;
            r_sig        <= n_sig;
            r_pend_valid <= n_pend_valid;
            r_pend_code  <= n_pend_code;
            r_mask       <= n_mask;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_index     <= n_index;
        r_bootable  <= n_bootable;
        r_type_code <= n_type_code;
        r_fs_class  <= n_fs_class;
        r_first     <= n_first;
        r_length    <= n_length;
        r_off_b     <= n_off_b;
        r_len_b     <= n_len_b;
        r_last      <= n_last;
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_entry_index    = r_index;
    assign o_bootable       = r_bootable;
    assign o_type_code      = r_type_code;
    assign o_fs_class       = r_fs_class;
    assign o_first_sector   = r_first;
    assign o_length_sectors = r_length;
    assign o_offset_bytes   = r_off_b;
    assign o_length_bytes   = r_len_b;
    assign o_last_of_run    = r_last;

    // a status record never shares the queue with entry records
    a_queue_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend_valid && (r_mask != 4'd0)))
        else $error("status and entry records queued together");

    // captured entries must hold while records are still queued
    a_entries_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> ($stable(r_type) && $stable(r_count) && $stable(r_start)
                  && $stable(r_boot)))
        else $error("entry state changed while records pending");

    a_status_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != ST_ENTRY)) |-> (r_last && (r_index == 3'd0)))
        else $error("status record malformed");

    a_entry_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_ENTRY)) |-> (r_index != 3'd0))
        else $error("entry record without index");

endmodule
